// ===== sv/bfsa_pkg.sv =====
package bfsa_pkg;

	// field widths of the stream words
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned SIZE_W = 17;
	localparam int unsigned NEED_W = 18;
	localparam int unsigned ALIGN_W = 4;

	localparam logic [SIZE_W-1:0] TOTAL_RESET = 17'd1024;
	localparam logic [SIZE_W-1:0] MEM_LIMIT = 17'd65536;
	localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd3;
	localparam logic [ALIGN_W-1:0] ALIGN_MAX = 4'd12;

	// configuration register indexes
	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_ALIGN = 1'b1;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_MEM = 3'd1,
		ST_BAD_FREE = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_ZERO_SIZE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_ALLOC_DEC,
		S_SHR,
		S_ALLOC_WR1,
		S_ALLOC_WR0,
		S_FREE_DEC,
		S_SHL,
		S_FREE_WR,
		S_DONE
	} state_t;

	// one segment table entry
	typedef struct packed {
		logic used;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] start;
	} seg_t;

endpackage

// ===== sv/best_fit_segment_allocator.sv =====
// Best-fit segment allocator with coalescing.
// Input words (s_axis_*) carry an allocate or free command, the command itself
// in s_axis_tuser; each gives exactly one result word (m_axis_*) with status,
// block address and free byte total.
// The segment table lives in a one-write, one-read memory of MAX_SEGMENTS
// entries kept in address order; entries at or above the count are never
// scanned. A command is accepted, then the N live segments are scanned; a
// split, or a free of a block that is found, then shifts the table entries
// above that segment, and one or two table writes precede the result step.
// The memory read port walks the table one entry per cycle. A zero-size
// allocate request goes straight from acceptance to the result step.
// s_axis_tready is high only while the sequencer waits for a command; it stays
// high while an earlier result waits in the output register, but a finished
// command holds in its result cycle until that register drains.
// Reset: managed size 1024, align_log2 3, one free segment; the first cycle
// after reset or after a managed-size write rewrites table entry 0 and takes
// no word. A managed-size write re-initializes the table; align_log2 only sets
// rounding. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
module best_fit_segment_allocator #(
	parameter int unsigned MAX_SEGMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] command
	input  logic        s_axis_tuser,
	// [16:0] request_bytes, [32:17] free_address, [39:33] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] status, [18:3] block_address, [35:19] free_total, [39:36] zero
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
	localparam int unsigned SW = bfsa_pkg::SIZE_W;
	localparam int unsigned AW = bfsa_pkg::ADDR_W;
	localparam int unsigned NW = bfsa_pkg::NEED_W;

	bfsa_pkg::state_t st_q, st_d;

	// configuration and totals
	logic [SW-1:0] tot_q;
	logic [3:0] align_q;
	logic [SW-1:0] free_sum_q;
	logic [CW-1:0] count_q;

	// command in flight
	logic cmd_q;
	logic [AW-1:0] addr_q;
	logic [NW-1:0] need_q;

	// table walker: read issue and registered read data
	logic [CW-1:0] cnt_q, rd_q;
	logic dn_q;
	logic vld_s1;
	logic [CW-1:0] idx_s1;
	bfsa_pkg::seg_t rd_s1;
	logic issue;

	// scan results
	logic fnd_q;
	logic [CW-1:0] best_q;
	logic [SW-1:0] bsize_q;
	logic [AW-1:0] bstart_q;
	bfsa_pkg::seg_t last_q, prev_q, nx_q;
	logic want_nx_q, nx_ok_q;

	// merge bookkeeping
	logic [1:0] d_q;
	logic [CW-1:0] tgt_q;
	bfsa_pkg::seg_t tgt_data_q;

	// result
	logic [2:0] res_status_q;
	logic [AW-1:0] res_addr_q;
	logic out_valid_q;
	logic [39:0] out_data_q;

	// memory
	bfsa_pkg::seg_t mem [MAX_SEGMENTS];
	logic we;
	logic [CW-1:0] waddr;
	bfsa_pkg::seg_t wdata;

	logic in_acc;
	logic cfg_total;
	logic [NW-1:0] req_ext, amask, need_in;
	logic hit;
	logic pf, nf;
	logic [SW-1:0] rem;
	logic [CW-1:0] p_sel;
	logic [1:0] d_sel;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_total = cfg_we && (cfg_index == bfsa_pkg::REG_TOTAL);
	assign issue = ((st_q == bfsa_pkg::S_SCAN) || (st_q == bfsa_pkg::S_SHR) ||
		(st_q == bfsa_pkg::S_SHL)) && (cnt_q != '0);

	// request rounded up to the alignment
	assign req_ext = NW'(s_axis_tdata[16:0]);
	assign amask = (NW'(1) << align_q) - NW'(1);
	assign need_in = (req_ext + amask) & ~amask;

	// scan hit on the entry coming out of the memory
	always_comb begin
		if (cmd_q == bfsa_pkg::CMD_ALLOC) begin
			hit = !rd_s1.used && (NW'(rd_s1.size) >= need_q) &&
				(!fnd_q || (rd_s1.size < bsize_q));
		end else begin
			hit = rd_s1.used && (rd_s1.start == addr_q) && !fnd_q;
		end
	end

	// merge cases and split remainder
	assign pf = (best_q != '0) && !prev_q.used;
	assign nf = nx_ok_q && !nx_q.used;
	assign rem = bsize_q - need_q[SW-1:0];
	assign p_sel = (!pf && nf) ? best_q + CW'(1) : best_q;
	assign d_sel = (pf && nf) ? 2'd2 : ((pf || nf) ? 2'd1 : 2'd0);

	// next state and memory write port
	always_comb begin
		st_d = st_q;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		s_axis_tready = 1'b0;
		unique case (st_q)
			bfsa_pkg::S_INIT: begin
				we = 1'b1;
				wdata.size = tot_q;
				st_d = bfsa_pkg::S_IDLE;
			end
			bfsa_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == bfsa_pkg::CMD_ALLOC && s_axis_tdata[16:0] == '0) begin
						st_d = bfsa_pkg::S_DONE;
					end else begin
						st_d = bfsa_pkg::S_SCAN;
					end
				end
			end
			bfsa_pkg::S_SCAN: begin
				if (cnt_q == '0 && !vld_s1) begin
					st_d = (cmd_q == bfsa_pkg::CMD_ALLOC) ? bfsa_pkg::S_ALLOC_DEC :
						bfsa_pkg::S_FREE_DEC;
				end
			end
			bfsa_pkg::S_ALLOC_DEC: begin
				if (!fnd_q) begin
					st_d = bfsa_pkg::S_DONE;
				end else if (rem != '0) begin
					st_d = (count_q >= CNT_MAX) ? bfsa_pkg::S_DONE : bfsa_pkg::S_SHR;
				end else begin
					st_d = bfsa_pkg::S_ALLOC_WR0;
				end
			end
			bfsa_pkg::S_SHR: begin
				we = vld_s1;
				waddr = idx_s1 + CW'(1);
				wdata = rd_s1;
				if (cnt_q == '0 && !vld_s1) begin
					st_d = bfsa_pkg::S_ALLOC_WR1;
				end
			end
			bfsa_pkg::S_ALLOC_WR1: begin
				we = 1'b1;
				waddr = best_q + CW'(1);
				wdata.used = 1'b0;
				wdata.size = rem;
				wdata.start = bstart_q + need_q[AW-1:0];
				st_d = bfsa_pkg::S_ALLOC_WR0;
			end
			bfsa_pkg::S_ALLOC_WR0: begin
				we = 1'b1;
				waddr = best_q;
				wdata.used = 1'b1;
				wdata.size = need_q[SW-1:0];
				wdata.start = bstart_q;
				st_d = bfsa_pkg::S_DONE;
			end
			bfsa_pkg::S_FREE_DEC: begin
				st_d = fnd_q ? bfsa_pkg::S_SHL : bfsa_pkg::S_DONE;
			end
			bfsa_pkg::S_SHL: begin
				we = vld_s1;
				waddr = idx_s1 - CW'(d_q);
				wdata = rd_s1;
				if (cnt_q == '0 && !vld_s1) begin
					st_d = bfsa_pkg::S_FREE_WR;
				end
			end
			bfsa_pkg::S_FREE_WR: begin
				we = 1'b1;
				waddr = tgt_q;
				wdata = tgt_data_q;
				st_d = bfsa_pkg::S_DONE;
			end
			bfsa_pkg::S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					st_d = bfsa_pkg::S_IDLE;
				end
			end
			default: st_d = bfsa_pkg::S_INIT;
		endcase
		if (cfg_total) begin
			st_d = bfsa_pkg::S_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bfsa_pkg::S_INIT;
		end else begin
			st_q <= st_d;
		end
	end

	// segment table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[IW-1:0]] <= wdata;
		end
		rd_s1 <= mem[rd_q[IW-1:0]];
		idx_s1 <= rd_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= bfsa_pkg::TOTAL_RESET;
			align_q <= bfsa_pkg::ALIGN_RESET;
			free_sum_q <= bfsa_pkg::TOTAL_RESET;
			count_q <= CW'(1);
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (in_acc) begin
				cnt_q <= count_q;
			end
			if (st_q == bfsa_pkg::S_ALLOC_DEC) begin
				cnt_q <= (fnd_q && rem != '0 && count_q < CNT_MAX) ?
					count_q - CW'(1) - best_q : '0;
			end
			if (st_q == bfsa_pkg::S_FREE_DEC) begin
				cnt_q <= fnd_q ? count_q - p_sel - CW'(d_sel) : '0;
				if (fnd_q) begin
					free_sum_q <= free_sum_q + bsize_q;
				end
			end
			if (st_q == bfsa_pkg::S_FREE_WR) begin
				count_q <= count_q - CW'(d_q);
			end
			if (st_q == bfsa_pkg::S_ALLOC_WR0) begin
				free_sum_q <= free_sum_q - need_q[SW-1:0];
				if (rem != '0) begin
					count_q <= count_q + CW'(1);
				end
			end
			// output register
			if (st_q == bfsa_pkg::S_DONE && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// configuration writes
			if (cfg_total) begin
				tot_q <= (cfg_data > bfsa_pkg::MEM_LIMIT) ? bfsa_pkg::MEM_LIMIT : cfg_data;
				free_sum_q <= (cfg_data > bfsa_pkg::MEM_LIMIT) ? bfsa_pkg::MEM_LIMIT : cfg_data;
				count_q <= CW'(1);
			end else if (cfg_we) begin
				align_q <= (cfg_data[3:0] > bfsa_pkg::ALIGN_MAX) ? bfsa_pkg::ALIGN_MAX :
					cfg_data[3:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_q <= dn_q ? rd_q - CW'(1) : rd_q + CW'(1);
		end
		unique case (st_q)
			bfsa_pkg::S_IDLE: begin
				cmd_q <= s_axis_tuser;
				addr_q <= s_axis_tdata[32:17];
				need_q <= need_in;
				rd_q <= '0;
				dn_q <= 1'b0;
				fnd_q <= 1'b0;
				want_nx_q <= 1'b0;
				nx_ok_q <= 1'b0;
				best_q <= '0;
				last_q <= '0;
				prev_q <= '0;
				res_status_q <= bfsa_pkg::ST_ZERO_SIZE;
				res_addr_q <= '0;
			end
			bfsa_pkg::S_SCAN: begin
				if (vld_s1) begin
					last_q <= rd_s1;
					if (hit) begin
						fnd_q <= 1'b1;
						best_q <= idx_s1;
						bsize_q <= rd_s1.size;
						bstart_q <= rd_s1.start;
						prev_q <= last_q;
						want_nx_q <= 1'b1;
					end else if (want_nx_q) begin
						nx_q <= rd_s1;
						nx_ok_q <= 1'b1;
						want_nx_q <= 1'b0;
					end
				end
			end
			bfsa_pkg::S_ALLOC_DEC: begin
				rd_q <= count_q - CW'(1);
				dn_q <= 1'b1;
				res_addr_q <= '0;
				if (!fnd_q) begin
					res_status_q <= bfsa_pkg::ST_NO_MEM;
				end else begin
					res_status_q <= (rem != '0 && count_q >= CNT_MAX) ?
						bfsa_pkg::ST_TABLE_FULL : bfsa_pkg::ST_OK;
				end
			end
			bfsa_pkg::S_ALLOC_WR0: begin
				res_addr_q <= bstart_q;
			end
			bfsa_pkg::S_FREE_DEC: begin
				res_addr_q <= addr_q;
				res_status_q <= fnd_q ? bfsa_pkg::ST_OK : bfsa_pkg::ST_BAD_FREE;
				rd_q <= p_sel + CW'(d_sel);
				dn_q <= 1'b0;
				d_q <= d_sel;
				tgt_data_q.used <= 1'b0;
				// merged entry: absorb into the left neighbor when it is free
				if (pf) begin
					tgt_q <= best_q - CW'(1);
					tgt_data_q.start <= prev_q.start;
					tgt_data_q.size <= prev_q.size + bsize_q + (nf ? nx_q.size : '0);
				end else begin
					tgt_q <= best_q;
					tgt_data_q.start <= bstart_q;
					tgt_data_q.size <= bsize_q + (nf ? nx_q.size : '0);
				end
			end
			default: begin
			end
		endcase
		if (st_q == bfsa_pkg::S_DONE && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {4'b0, free_sum_q, res_addr_q, res_status_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// the table always holds at least one and at most MAX_SEGMENTS entries
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_MAX))
		else $error("segment count out of range");

	// free bytes never exceed the managed size
	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		free_sum_q <= tot_q)
		else $error("free total above managed size");

	// commands are only taken by the idle sequencer
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (st_q == bfsa_pkg::S_IDLE))
		else $error("ready outside idle");

	// table writes stay below the segment limit
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (waddr < CNT_MAX))
		else $error("table write out of range");

	// an accepted command leaves idle at once
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !cfg_we) |=> (st_q != bfsa_pkg::S_IDLE))
		else $error("command accepted but sequencer stayed idle");

endmodule
